/* rtl/rrdt_pkg.sv */
// Shared types and constants for the round-robin dispatch tracker.
// No dependencies; every other file imports this package.

package rrdt_pkg;

    // Operation codes carried in the func field
    localparam logic FUNC_SEND = 1'b0;
    localparam logic FUNC_RECV = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_NONE = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;
    localparam logic [1:0] STATUS_FULL = 2'd3;

    localparam int unsigned CFG_W    = 5;
    localparam int unsigned WORKER_W = 4;

    typedef struct packed {
        logic func;
        logic call_ok;
    } in_item_t;

    typedef struct packed {
        logic [WORKER_W-1:0] worker;
        logic [1:0]          status;
    } out_item_t;

    // Command broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;   // place the token at the start cell
        logic shift;  // move the token one cell along
        logic inc;    // count up in the cell holding the token
        logic dec;    // count down in the cell holding the token
    } cell_cmd_t;

    // Flags a cell reports back
    typedef struct packed {
        logic wrap;   // token leaves the last cell in rotation
        logic hit;    // token here and count non-zero
        logic full;   // token here and count saturated
    } cell_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } seq_state_t;

endpackage

/* rtl/round_robin_dispatch_tracker.sv */
// Top level of the round-robin dispatch tracker: sequencer, result register
// and the row of worker cells. Depends on rrdt_pkg and rrdt_cell.

// The tracker takes one transfer at a time and returns exactly one result per
// transfer. A send is aimed at the worker under the send pointer: the token is
// placed on that cell, the send is decided, and the result is loaded into the
// output register once it is free. A receive walks a token along the row of
// worker cells, one cell per cycle, starting at the receive pointer, until it
// finds a worker with a non-zero count or has tried every worker in rotation.
// A stale pointer falls back to worker zero. A new transfer is accepted
// once the previous one has reached the output register, even while that
// result still waits to be taken. The worker count register is written over
// its own valid/ready channel, which is always ready; write it only while the
// block is idle. A count of zero acts as one and a count above MAX_WORKERS as
// MAX_WORKERS. Result worker indices are reported in four bits.

module round_robin_dispatch_tracker #(
    parameter int unsigned MAX_WORKERS = 16,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrdt_pkg::CFG_W-1:0]    cfg_worker_count,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rrdt_pkg::in_item_t            s_data,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output rrdt_pkg::out_item_t           m_data
);
    import rrdt_pkg::*;

    localparam int unsigned IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int unsigned NW    = $clog2(MAX_WORKERS + 1);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(1);
        end else if (cfg_valid) begin
            cfg_reg <= cfg_worker_count;
        end
    end

    // Effective worker count: clamp to the range one to MAX_WORKERS
    logic [NW-1:0]    n_eff;
    logic [IDX_W-1:0] last_idx;

    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(cfg_reg) > 32'(MAX_WORKERS)) begin
            n_eff = NW'(MAX_WORKERS);
        end else begin
            n_eff = NW'(cfg_reg);
        end
    end

    // Highest index in rotation; always below MAX_WORKERS so it fits
    logic [NW-1:0] n_minus_one;
    assign n_minus_one = n_eff - 1'b1;
    assign last_idx    = n_minus_one[IDX_W-1:0];

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    seq_state_t          state_reg,     state_next;
    logic                func_reg,      func_next;
    logic                ok_reg,        ok_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic [IDX_W-1:0]    steps_reg,     steps_next;
    logic [IDX_W-1:0]    send_ptr_reg,  send_ptr_next;
    logic [IDX_W-1:0]    recv_ptr_reg,  recv_ptr_next;
    logic [IDX_W-1:0]    res_idx_reg,   res_idx_next;
    logic [1:0]          res_stat_reg,  res_stat_next;
    out_item_t           m_data_reg,    m_data_next;
    logic                m_valid_reg,   m_valid_next;

    cell_cmd_t           cmd;
    logic [IDX_W-1:0]    start_idx;
    logic [IDX_W-1:0]    idx_adv;
    logic                any_hit;
    logic                any_full;
    logic                any_wrap;
    logic                s_fire;
    logic [IDX_W+WORKER_W-1:0] res_idx_wide;

    // ---------------------------------------------------------------
    // Row of worker cells
    // ---------------------------------------------------------------
    logic        [MAX_WORKERS-1:0] tok_chain;
    cell_flags_t [MAX_WORKERS-1:0] flags;
    logic        [MAX_WORKERS-1:0] wrap_vec;
    logic        [MAX_WORKERS-1:0] hit_vec;
    logic        [MAX_WORKERS-1:0] full_vec;

    for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
        logic tok_in;
        if (g == 0) begin : g_head
            // token leaving the last cell in rotation comes back here
            assign tok_in = any_wrap;
        end else begin : g_body
            assign tok_in = tok_chain[g-1];
        end

        rrdt_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .start_idx (start_idx),
            .last_idx  (last_idx),
            .tok_in    (tok_in),
            .tok_out   (tok_chain[g]),
            .flags     (flags[g])
        );

        assign wrap_vec[g] = flags[g].wrap;
        assign hit_vec[g]  = flags[g].hit;
        assign full_vec[g] = flags[g].full;
    end

    assign any_wrap = |wrap_vec;
    assign any_hit  = |hit_vec;
    assign any_full = |full_vec;

    // ---------------------------------------------------------------
    // Next state and outputs
    // ---------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // Step forward with wrap at the effective count
    assign idx_adv = (idx_reg == last_idx) ? '0 : idx_reg + 1'b1;

    // Start cell: the relevant pointer, or zero if it went stale
    always_comb begin
        if (s_data.func == FUNC_SEND) begin
            start_idx = (NW'(send_ptr_reg) < n_eff) ? send_ptr_reg : '0;
        end else begin
            start_idx = (NW'(recv_ptr_reg) < n_eff) ? recv_ptr_reg : '0;
        end
    end

    assign res_idx_wide = {{WORKER_W{1'b0}}, res_idx_reg};

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        ok_next       = ok_reg;
        idx_next      = idx_reg;
        steps_next    = steps_reg;
        send_ptr_next = send_ptr_reg;
        recv_ptr_next = recv_ptr_reg;
        res_idx_next  = res_idx_reg;
        res_stat_next = res_stat_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        cmd           = '0;

        // drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // latch the request and park the token on the start cell
                    func_next  = s_data.func;
                    ok_next    = s_data.call_ok;
                    idx_next   = start_idx;
                    steps_next = '0;
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (func_reg == FUNC_SEND) begin
                    res_idx_next = idx_reg;
                    state_next   = ST_OUT;
                    if (any_full) begin
                        res_stat_next = STATUS_FULL;
                    end else if (!ok_reg) begin
                        res_stat_next = STATUS_FAIL;
                    end else begin
                        res_stat_next = STATUS_DONE;
                        cmd.inc       = 1'b1;
                        send_ptr_next = idx_adv;
                    end
                end else begin
                    if (any_hit) begin
                        res_idx_next = idx_reg;
                        state_next   = ST_OUT;
                        if (!ok_reg) begin
                            res_stat_next = STATUS_FAIL;
                        end else begin
                            res_stat_next = STATUS_DONE;
                            cmd.dec       = 1'b1;
                            recv_ptr_next = idx_adv;
                        end
                    end else if (steps_reg == last_idx) begin
                        // every worker in rotation is empty
                        res_idx_next  = '0;
                        res_stat_next = STATUS_NONE;
                        state_next    = ST_OUT;
                    end else begin
                        // advance the token to the next worker
                        cmd.shift  = 1'b1;
                        idx_next   = idx_adv;
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end

            ST_OUT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.worker = res_idx_wide[WORKER_W-1:0];
                    m_data_next.status = res_stat_reg;
                    m_valid_next       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            send_ptr_reg <= '0;
            recv_ptr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            send_ptr_reg <= send_ptr_next;
            recv_ptr_reg <= recv_ptr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        ok_reg       <= ok_next;
        idx_reg      <= idx_next;
        steps_reg    <= steps_next;
        res_idx_reg  <= res_idx_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/rrdt_cell.sv */
// One worker cell: holds the in-flight count for one worker and one token bit.
// Depends on rrdt_pkg.

module rrdt_cell #(
    parameter int unsigned CELL_INDEX = 0,
    parameter int unsigned IDX_W      = 4,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrdt_pkg::cell_cmd_t  cmd,
    input  logic [IDX_W-1:0]     start_idx,
    input  logic [IDX_W-1:0]     last_idx,
    input  logic                 tok_in,
    output logic                 tok_out,
    output rrdt_pkg::cell_flags_t flags
);
    import rrdt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic                  tok_reg;
    logic                  tok_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  is_last;

    assign is_last = (last_idx == MY_IDX);

    always_comb begin
        tok_next = tok_reg;
        if (cmd.load) begin
            tok_next = (start_idx == MY_IDX);
        end else if (cmd.shift) begin
            tok_next = tok_in;
        end
        count_next = count_reg;
        if (tok_reg && cmd.inc) begin
            count_next = count_reg + 1'b1;
        end else if (tok_reg && cmd.dec) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= 1'b0;
            count_reg <= '0;
        end else begin
            tok_reg   <= tok_next;
            count_reg <= count_next;
        end
    end

    // Hand the token on, unless this is the last cell in rotation
    assign tok_out    = tok_reg && !is_last;
    assign flags.wrap = tok_reg && is_last;
    assign flags.hit  = tok_reg && (count_reg != '0);
    assign flags.full = tok_reg && (count_reg == '1);

endmodule

/* rtl/rrdt_checker.sv */
// Port-level checks for the round-robin dispatch tracker, bound to the top level.
// Depends on rrdt_pkg and round_robin_dispatch_tracker.

module rrdt_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input rrdt_pkg::out_item_t        m_data
);
    import rrdt_pkg::*;

    // No result is shown straight after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // One transfer at a time: no back-to-back acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transfer is in progress");

    // Nothing pending always names worker zero
    a_none_worker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_NONE) |-> (m_data.worker == '0))
        else $error("nothing-pending result names a worker");

endmodule

bind round_robin_dispatch_tracker rrdt_checker u_rrdt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/round_robin_dispatch_tracker_test.sv */
// Self-checking testbench for round_robin_dispatch_tracker: a directed table
// and randomised phases over several worker counts.
// Depends on rrdt_pkg and the tracker RTL; results are checked by a predictor or typed answers.
`timescale 1ns / 1ps

module round_robin_dispatch_tracker_test;
    import rrdt_pkg::*;

    localparam int unsigned MAX_WORKERS  = 16;
    localparam int unsigned COUNT_BITS   = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int unsigned RANDOM_ITEMS = 850;
    localparam int unsigned PHASES       = 10;
    // Hang limit for under 900 transfers, with ample margin
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    // Longest receive walk plus the output register, with margin
    localparam int unsigned TAIL_CYCLES  = 2 + MAX_WORKERS + 12;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [CFG_W-1:0]    cfg_value;
        in_item_t            item;
        bit                  typed;
        out_item_t           result;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_worker_count;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;

    // Shadow of the block's state, advanced once per accepted transfer
    logic [CFG_W-1:0]      worker_count_model;
    logic [WORKER_W-1:0]   send_ptr_model;
    logic [WORKER_W-1:0]   recv_ptr_model;
    logic [COUNT_BITS-1:0] inflight_model [MAX_WORKERS];

    out_item_t    pending_results [$];
    stim_row_t    directed_rows [$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    bit           no_idle = 1'b0;

    round_robin_dispatch_tracker #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_worker_count (cfg_worker_count),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Abandon the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("round_robin_dispatch_tracker regression: fail");
            $finish;
        end
    end

    function automatic int unsigned rotate_next(int unsigned idx, int unsigned n);
        return (idx + 1 >= n) ? 0 : idx + 1;
    endfunction

    // Work out the result of one transfer and advance the shadow state with it
    function automatic out_item_t predict_dispatch(in_item_t it);
        int unsigned n;
        int unsigned w;
        int unsigned idx;
        int unsigned i;
        bit          found;
        out_item_t   res;
        res   = '0;
        w     = 0;
        found = 1'b0;
        // Zero behaves as one, anything above the row length as the row length
        if (worker_count_model == 0)
            n = 1;
        else if (worker_count_model > MAX_WORKERS)
            n = MAX_WORKERS;
        else
            n = worker_count_model;

        if (it.func == FUNC_SEND) begin
            // A stale pointer from a larger rotation falls back to worker zero
            w = (send_ptr_model < n) ? send_ptr_model : 0;
            if (inflight_model[w] == COUNT_MAX) begin
                res.status = STATUS_FULL;
            end else if (!it.call_ok) begin
                res.status = STATUS_FAIL;
            end else begin
                inflight_model[w] = inflight_model[w] + 1'b1;
                send_ptr_model    = WORKER_W'(rotate_next(w, n));
                res.status        = STATUS_DONE;
            end
        end else begin
            idx = (recv_ptr_model < n) ? recv_ptr_model : 0;
            for (i = 0; i < n && !found; i++) begin
                if (inflight_model[idx] != 0)
                    found = 1'b1;
                else
                    idx = rotate_next(idx, n);
            end
            if (!found) begin
                res.status = STATUS_NONE;
            end else begin
                w = idx;
                if (!it.call_ok) begin
                    res.status = STATUS_FAIL;
                end else begin
                    inflight_model[idx] = inflight_model[idx] - 1'b1;
                    recv_ptr_model      = WORKER_W'(rotate_next(idx, n));
                    res.status          = STATUS_DONE;
                end
            end
        end
        res.worker = WORKER_W'(w);
        return res;
    endfunction

    // Offer one transfer after a random gap; predict it once accepted
    task automatic transfer_item(in_item_t it, bit typed, out_item_t typed_result);
        int unsigned gap;
        out_item_t   predicted;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_dispatch(it);
        // Typed rows carry their own answer; the shadow state still advances
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Drop valid and hold until every outstanding result has been taken;
    // the wait is a do-while, so valid is never lowered and raised in one step
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Write the worker count only once the block has gone idle
    task automatic program_worker_count(logic [CFG_W-1:0] value);
        hold_until_drained();
        cfg_valid        <= 1'b1;
        cfg_worker_count <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid          <= 1'b0;
        worker_count_model  = value;
    endtask

    task automatic table_row(row_kind_t kind, logic [CFG_W-1:0] cfg_value, logic func,
                             logic call_ok, bit typed, logic [WORKER_W-1:0] worker,
                             logic [1:0] status);
        stim_row_t row;
        row.kind           = kind;
        row.cfg_value      = cfg_value;
        row.item.func      = func;
        row.item.call_ok   = call_ok;
        row.typed          = typed;
        row.result.worker  = worker;
        row.result.status  = status;
        directed_rows.push_back(row);
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected, actual worker %0d status %0d",
                         $time, m_data.worker, m_data.status);
            end else begin
                if (m_data.worker !== pending_results[0].worker) begin
                    error_count++;
                    $display("%0t: worker mismatch, expected %0d, actual %0d",
                             $time, pending_results[0].worker, m_data.worker);
                end
                if (m_data.status !== pending_results[0].status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, pending_results[0].status, m_data.status);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Result side: stall a random number of cycles before taking each transfer
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int unsigned       phase;
        int unsigned       k;
        int unsigned       recv_pct;
        logic [CFG_W-1:0]  plan;
        in_item_t          it;

        // Drive every input to a known value from time zero
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_worker_count = '0;
        s_valid          = 1'b0;
        s_data           = '0;

        worker_count_model = 5'd1;
        send_ptr_model     = '0;
        recv_ptr_model     = '0;
        for (k = 0; k < MAX_WORKERS; k++)
            inflight_model[k] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: typed answers after reset and for zero as count,
        // predictor elsewhere
        // Nothing pending straight after reset, whatever call_ok says
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b1, 0, STATUS_NONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b0, 1'b1, 0, STATUS_NONE);
        // Failed send leaves the count alone, then a good one
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b0, 1'b1, 0, STATUS_FAIL);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b1, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b0, 1'b1, 0, STATUS_FAIL);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b1, 0, STATUS_DONE);
        // A worker count of zero behaves as one
        table_row(ROW_CFG, 5'd0, FUNC_SEND, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b1, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b1, 0, STATUS_DONE);
        // Full row of workers
        table_row(ROW_CFG, 5'd16, FUNC_SEND, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);
        // Count above the row length clamps to the row length
        table_row(ROW_CFG, 5'd31, FUNC_SEND, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);
        // Shrink the rotation: both pointers go stale, workers beyond it keep counts
        table_row(ROW_CFG, 5'd2, FUNC_SEND, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_SEND, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);
        // Grow it again so the stranded counts come back into the scan
        table_row(ROW_CFG, 5'd4, FUNC_SEND, 1'b0, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);
        table_row(ROW_ITEM, 0, FUNC_RECV, 1'b1, 1'b0, 0, STATUS_DONE);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                program_worker_count(directed_rows[r].cfg_value);
            else
                transfer_item(directed_rows[r].item, directed_rows[r].typed,
                              directed_rows[r].result);
        end

        // Random phases, each under its own worker count and send/receive mix
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: plan = 5'd16;
                1: plan = 5'd1;
                2: plan = 5'd31;
                3: plan = 5'd0;
                4: plan = CFG_W'($urandom_range(1, 16));
                5: plan = 5'd2;
                6: plan = CFG_W'($urandom_range(0, 31));
                7: plan = 5'd16;
                8: plan = 5'd3;
                default: plan = CFG_W'($urandom_range(0, 31));
            endcase
            program_worker_count(plan);
            // Every fourth phase runs back to back on both sides
            no_idle  = (phase % 4 == 3);
            recv_pct = $urandom_range(30, 70);
            for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
                it.func    = ($urandom_range(0, 99) < recv_pct) ? FUNC_RECV : FUNC_SEND;
                it.call_ok = ($urandom_range(0, 99) < 85);
                transfer_item(it, 1'b0, '0);
                // Now and then hold the sender until the result side has caught up
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
            end
        end

        // Drain, then watch a little longer for stray results
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("round_robin_dispatch_tracker regression: pass");
        end else begin
            $display("round_robin_dispatch_tracker regression: fail");
        end
        $finish;
    end

endmodule
